FILE: src/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// shared widths, case codes and payload types of the quadratic root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

   // coefficient format: signed, CW bits
   localparam int CW     = 16;
   localparam int MW     = CW + 1;          // coefficient magnitude
   localparam int DW     = 2 * CW + 3;      // discriminant magnitude
   localparam int SW     = (DW + 1) / 2;    // square root result
   localparam int NMW    = CW + 3;          // numerator magnitude
   localparam int NSW    = NMW + 1;         // signed numerator
   localparam int DVW    = CW + 2;          // divisor magnitude
   localparam int RFB    = 16;              // root fraction bits
   localparam int QW     = NMW + RFB;       // quotient
   localparam int TOLW   = 20;              // tolerance register
   localparam int CASEW  = 3;

   localparam logic [CASEW-1:0] CASE_NONE   = 3'd0;
   localparam logic [CASEW-1:0] CASE_LINEAR = 3'd1;
   localparam logic [CASEW-1:0] CASE_DOUBLE = 3'd2;
   localparam logic [CASEW-1:0] CASE_TWO    = 3'd3;
   localparam logic [CASEW-1:0] CASE_NEG    = 3'd4;

   typedef struct packed {
      logic signed [CW-1:0] coeff_square;
      logic signed [CW-1:0] coeff_linear;
      logic signed [CW-1:0] coeff_constant;
   } qrs_req_type;

   typedef struct packed {
      logic [CASEW-1:0]   root_case;
      logic signed [31:0] first_root;
      logic signed [31:0] second_root;
      logic               overflow;
   } qrs_rsp_type;

   // context carried alongside the square root
   typedef struct packed {
      logic [CASEW-1:0] rcase;
      logic             aneg;
      logic             bneg;
      logic             cneg;
      logic [MW-1:0]    amag;
      logic [MW-1:0]    bmag;
      logic [MW-1:0]    cmag;
   } qrs_ctx_type;

   // context carried alongside the divider
   typedef struct packed {
      logic [CASEW-1:0] rcase;
      logic             neg1;
      logic             neg2;
   } qrs_dtag_type;

   // pipeline control shared by the sub-pipelines
   typedef struct packed {
      logic advance;
      logic valid;
   } qrs_ctl_type;

endpackage

FILE: src/qrs_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_pipe
// floor square root, one result bit per pipeline stage
// ----------------------------------------------------------------------------
module qrs_sqrt_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  qrs_pkg::qrs_ctl_type  in_ctl,
   input  logic [qrs_pkg::DW-1:0] in_rad,
   input  qrs_pkg::qrs_ctx_type  in_ctx,
   output logic                  out_valid,
   output logic [qrs_pkg::SW-1:0] out_root,
   output qrs_pkg::qrs_ctx_type  out_ctx
);
   import qrs_pkg::*;

   localparam int TW = 2 * SW;

   logic            valid_ff [SW];
   logic [TW-1:0]   rem_ff   [SW];
   logic [SW-1:0]   root_ff  [SW];
   qrs_ctx_type     ctx_ff   [SW];

   for (genvar i = 0; i < SW; i++) begin : g_stage
      localparam int K = SW - 1 - i;
      logic            valid_in;
      logic [TW-1:0]   rem_prev;
      logic [SW-1:0]   root_prev;
      qrs_ctx_type     ctx_in;
      logic [TW-1:0]   term;
      logic [TW-1:0]   rem_in;
      logic [SW-1:0]   root_in;

      if (i == 0) begin : g_first
         assign valid_in  = in_ctl.valid;
         assign rem_prev  = TW'(in_rad);
         assign root_prev = '0;
         assign ctx_in    = in_ctx;
      end else begin : g_next
         assign valid_in  = valid_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign ctx_in    = ctx_ff[i-1];
      end

      // (r + 2^k)^2 - r^2
      assign term = (TW'(root_prev) << (K + 1)) | (TW'(1) << (2 * K));

      always_comb begin
         if (rem_prev >= term) begin
            rem_in  = rem_prev - term;
            root_in = root_prev | (SW'(1) << K);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (in_ctl.advance) begin
            valid_ff[i] <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         if (in_ctl.advance) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            ctx_ff[i]  <= ctx_in;
         end
      end
   end

   assign out_valid = valid_ff[SW-1];
   assign out_root  = root_ff[SW-1];
   assign out_ctx   = ctx_ff[SW-1];

endmodule

FILE: src/qrs_div_pipe.sv
// ----------------------------------------------------------------------------
// qrs_div_pipe
// two-lane restoring divider sharing one divisor, one quotient bit per stage
// ----------------------------------------------------------------------------
module qrs_div_pipe (
   input  logic                    clock,
   input  logic                    reset,
   input  qrs_pkg::qrs_ctl_type    in_ctl,
   input  logic [qrs_pkg::NMW-1:0] in_num1,
   input  logic [qrs_pkg::NMW-1:0] in_num2,
   input  logic [qrs_pkg::DVW-1:0] in_div,
   input  qrs_pkg::qrs_dtag_type   in_tag,
   output logic                    out_valid,
   output logic [qrs_pkg::QW-1:0]  out_quo1,
   output logic [qrs_pkg::QW-1:0]  out_quo2,
   output qrs_pkg::qrs_dtag_type   out_tag
);
   import qrs_pkg::*;

   logic            valid_ff [QW];
   logic [DVW-1:0]  div_ff   [QW];
   logic [DVW-1:0]  rem1_ff  [QW];
   logic [DVW-1:0]  rem2_ff  [QW];
   logic [QW-1:0]   dvd1_ff  [QW];
   logic [QW-1:0]   dvd2_ff  [QW];
   logic [QW-1:0]   quo1_ff  [QW];
   logic [QW-1:0]   quo2_ff  [QW];
   qrs_dtag_type    tag_ff   [QW];

   // one restoring step: returns {quotient bit, new remainder}
   function automatic logic [DVW:0] div_step(input logic [DVW-1:0] rem,
                                             input logic           bit_in,
                                             input logic [DVW-1:0] dv);
      logic [DVW:0] sh;
      logic [DVW:0] df;
      sh = {rem, bit_in};
      df = sh - {1'b0, dv};
      if (sh >= {1'b0, dv}) begin
         return {1'b1, df[DVW-1:0]};
      end
      return {1'b0, sh[DVW-1:0]};
   endfunction

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic           valid_in;
      logic [DVW-1:0] div_prev;
      logic [DVW-1:0] rem1_prev;
      logic [DVW-1:0] rem2_prev;
      logic [QW-1:0]  dvd1_prev;
      logic [QW-1:0]  dvd2_prev;
      logic [QW-1:0]  quo1_prev;
      logic [QW-1:0]  quo2_prev;
      qrs_dtag_type   tag_in;
      logic [DVW:0]   step1;
      logic [DVW:0]   step2;

      if (i == 0) begin : g_first
         assign valid_in  = in_ctl.valid;
         assign div_prev  = in_div;
         assign rem1_prev = '0;
         assign rem2_prev = '0;
         assign dvd1_prev = {in_num1, RFB'(0)};
         assign dvd2_prev = {in_num2, RFB'(0)};
         assign quo1_prev = '0;
         assign quo2_prev = '0;
         assign tag_in    = in_tag;
      end else begin : g_next
         assign valid_in  = valid_ff[i-1];
         assign div_prev  = div_ff[i-1];
         assign rem1_prev = rem1_ff[i-1];
         assign rem2_prev = rem2_ff[i-1];
         assign dvd1_prev = dvd1_ff[i-1];
         assign dvd2_prev = dvd2_ff[i-1];
         assign quo1_prev = quo1_ff[i-1];
         assign quo2_prev = quo2_ff[i-1];
         assign tag_in    = tag_ff[i-1];
      end

      assign step1 = div_step(rem1_prev, dvd1_prev[QW-1], div_prev);
      assign step2 = div_step(rem2_prev, dvd2_prev[QW-1], div_prev);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (in_ctl.advance) begin
            valid_ff[i] <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         if (in_ctl.advance) begin
            div_ff[i]  <= div_prev;
            rem1_ff[i] <= step1[DVW-1:0];
            rem2_ff[i] <= step2[DVW-1:0];
            dvd1_ff[i] <= dvd1_prev << 1;
            dvd2_ff[i] <= dvd2_prev << 1;
            quo1_ff[i] <= {quo1_prev[QW-2:0], step1[DVW]};
            quo2_ff[i] <= {quo2_prev[QW-2:0], step2[DVW]};
            tag_ff[i]  <= tag_in;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quo1  = quo1_ff[QW-1];
   assign out_quo2  = quo2_ff[QW-1];
   assign out_tag   = tag_ff[QW-1];

endmodule

FILE: src/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// real roots of a*x^2 + b*x + c = 0, signed Q16.16 out, fully pipelined
// ----------------------------------------------------------------------------
// usage
//  - req channel: one request carries a, b, c (signed Q8.8) with valid/ready
//  - rsp channel: one result per request: case code, two roots, overflow flag
//  - csr port: APB-style, register 0 at byte address 0 is the 20-bit double
//    root tolerance; write it only while no request is in flight
//  - throughput: one request per clock while the output is not stalled; the
//    pipeline is a chain of registers (prep, multiply, discriminant, classify,
//    one stage per square root bit, numerator select, one stage per quotient
//    bit, saturate)
//  - widths: SW = 18 root bits, QW = 35 quotient bits at 16-bit coefficients
//  - stall: when rsp_valid is high and rsp_ready low the whole pipeline holds,
//    so req_ready drops; nothing is dropped or repeated
//  - reset: synchronous, clears every stage valid bit and the tolerance
// ----------------------------------------------------------------------------
module quadratic_root_solver (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  qrs_pkg::qrs_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output qrs_pkg::qrs_rsp_type rsp_payload,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import qrs_pkg::*;

   // whole pipeline moves together when the output slot is free or taken
   logic advance;

   // csr
   logic [TOLW-1:0] tol_ff;

   // stage 1: magnitudes and signs
   logic            s1_valid_ff;
   logic            s1_aneg_ff, s1_bneg_ff, s1_cneg_ff;
   logic [MW-1:0]   s1_amag_ff, s1_bmag_ff, s1_cmag_ff;
   logic [CASEW-1:0] s1_case_ff;
   logic [MW-1:0]   s1_amag_in, s1_bmag_in, s1_cmag_in;
   logic [CASEW-1:0] s1_case_in;

   // stage 2: products
   logic            s2_valid_ff;
   qrs_ctx_type     s2_ctx_ff;
   logic [2*MW-1:0] s2_bb_ff;
   logic [2*MW-1:0] s2_ac_ff;

   // stage 3: discriminant
   logic            s3_valid_ff;
   qrs_ctx_type     s3_ctx_ff;
   logic [DW-1:0]   s3_dmag_ff;
   logic            s3_dneg_ff;
   logic [DW-1:0]   s3_dmag_in;
   logic            s3_dneg_in;
   logic [DW-1:0]   b2_ext, p4_ext;
   logic [DW:0]     d_sub;

   // stage 4: classify
   logic            s4_valid_ff;
   qrs_ctx_type     s4_ctx_ff;
   qrs_ctx_type     s4_ctx_in;
   logic [DW-1:0]   s4_dmag_ff;
   logic [CASEW-1:0] s4_case_in;

   // square root pipe
   qrs_ctl_type     sq_ctl;
   qrs_ctx_type     s4_ctx_fwd;
   logic            sq_valid;
   logic [SW-1:0]   sq_root;
   qrs_ctx_type     sq_ctx;

   // stage 5: numerators and divisor
   logic            s5_valid_ff;
   logic [NMW-1:0]  s5_num1_ff, s5_num2_ff;
   logic [DVW-1:0]  s5_div_ff;
   qrs_dtag_type    s5_tag_ff;
   logic signed [NSW-1:0] nb_s, nc_s, s_s, n1_s, n2_s;
   logic [NMW-1:0]  n1_mag, n2_mag;
   logic [DVW-1:0]  div_in;
   logic            dneg_in;
   qrs_dtag_type    tag_in;

   // divider pipe
   qrs_ctl_type     dv_ctl;
   logic            dv_valid;
   logic [QW-1:0]   dv_quo1, dv_quo2;
   qrs_dtag_type    dv_tag;

   // output register
   logic            out_valid_ff;
   qrs_rsp_type     out_ff;
   qrs_rsp_type     out_in;
   logic [32:0]     sat1, sat2;

   // magnitude of a signed coefficient
   function automatic logic [MW-1:0] coeff_mag(input logic [CW-1:0] raw);
      logic [MW-1:0] ext;
      ext = {raw[CW-1], raw};
      return raw[CW-1] ? MW'(MW'(0) - ext) : ext;
   endfunction

   // signed quotient with saturation: {overflow, root}
   function automatic logic [32:0] root_sat(input logic [QW-1:0] q,
                                            input logic          neg);
      logic [31:0] lo;
      lo = q[31:0];
      if (q == '0) begin
         return 33'd0;
      end
      if (!neg) begin
         if (q > QW'(32'h7FFF_FFFF)) begin
            return {1'b1, 32'h7FFF_FFFF};
         end
         return {1'b0, lo};
      end
      if (q > QW'(32'h8000_0000)) begin
         return {1'b1, 32'h8000_0000};
      end
      return {1'b0, 32'd0 - lo};
   endfunction

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? 32'(tol_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == 1'b0) begin
         tol_ff <= csr_pwdata[TOLW-1:0];
      end
   end

   // ---------------------------------------------------------------- stage 1
   assign s1_amag_in = coeff_mag(req_payload.coeff_square);
   assign s1_bmag_in = coeff_mag(req_payload.coeff_linear);
   assign s1_cmag_in = coeff_mag(req_payload.coeff_constant);

   // early case: a and b zero, or a zero only; else decided at stage 4
   always_comb begin
      if (s1_amag_in == '0 && s1_bmag_in == '0) begin
         s1_case_in = CASE_NONE;
      end else if (s1_amag_in == '0) begin
         s1_case_in = CASE_LINEAR;
      end else begin
         s1_case_in = CASE_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_aneg_ff <= req_payload.coeff_square[CW-1];
         s1_bneg_ff <= req_payload.coeff_linear[CW-1];
         s1_cneg_ff <= req_payload.coeff_constant[CW-1];
         s1_amag_ff <= s1_amag_in;
         s1_bmag_ff <= s1_bmag_in;
         s1_cmag_ff <= s1_cmag_in;
         s1_case_ff <= s1_case_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_bb_ff  <= s1_bmag_ff * s1_bmag_ff;
         s2_ac_ff  <= s1_amag_ff * s1_cmag_ff;
         s2_ctx_ff <= '{rcase: s1_case_ff, aneg: s1_aneg_ff, bneg: s1_bneg_ff,
                        cneg: s1_cneg_ff, amag: s1_amag_ff, bmag: s1_bmag_ff,
                        cmag: s1_cmag_ff};
      end
   end

   // ---------------------------------------------------------------- stage 3
   // |b^2 - 4ac| with its sign; opposite signs of a and c always add
   assign b2_ext = DW'(s2_bb_ff);
   assign p4_ext = DW'({s2_ac_ff, 2'b00});
   assign d_sub  = {1'b0, b2_ext} - {1'b0, p4_ext};

   always_comb begin
      if (s2_ctx_ff.cmag != '0 && s2_ctx_ff.aneg != s2_ctx_ff.cneg) begin
         s3_dmag_in = b2_ext + p4_ext;
         s3_dneg_in = 1'b0;
      end else if (!d_sub[DW]) begin
         s3_dmag_in = d_sub[DW-1:0];
         s3_dneg_in = 1'b0;
      end else begin
         s3_dmag_in = p4_ext - b2_ext;
         s3_dneg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_ctx_ff  <= s2_ctx_ff;
         s3_dmag_ff <= s3_dmag_in;
         s3_dneg_ff <= s3_dneg_in;
      end
   end

   // ---------------------------------------------------------------- stage 4
   // tolerance test comes before the sign test
   always_comb begin
      if (s3_ctx_ff.rcase != CASE_TWO) begin
         s4_case_in = s3_ctx_ff.rcase;
      end else if (s3_dmag_ff <= DW'(tol_ff)) begin
         s4_case_in = CASE_DOUBLE;
      end else if (!s3_dneg_ff) begin
         s4_case_in = CASE_TWO;
      end else begin
         s4_case_in = CASE_NEG;
      end
   end

   always_comb begin
      s4_ctx_in       = s3_ctx_ff;
      s4_ctx_in.rcase = s4_case_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_ctx_ff  <= s4_ctx_in;
         s4_dmag_ff <= s3_dmag_ff;
      end
   end

   // ---------------------------------------------------------------- sqrt
   assign sq_ctl     = '{advance: advance, valid: s4_valid_ff};
   assign s4_ctx_fwd = s4_ctx_ff;

   qrs_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (sq_ctl),
      .in_rad    (s4_dmag_ff),
      .in_ctx    (s4_ctx_fwd),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_ctx   (sq_ctx)
   );

   // ---------------------------------------------------------------- stage 5
   // -b, -c and -b +/- s as signed values, then sign and magnitude
   assign nb_s = sq_ctx.bneg ? NSW'(sq_ctx.bmag) : NSW'(NSW'(0) - NSW'(sq_ctx.bmag));
   assign nc_s = sq_ctx.cneg ? NSW'(sq_ctx.cmag) : NSW'(NSW'(0) - NSW'(sq_ctx.cmag));
   assign s_s  = NSW'(sq_root);

   always_comb begin
      n2_s = '0;
      case (sq_ctx.rcase)
         CASE_LINEAR: begin
            n1_s    = nc_s;
            div_in  = DVW'(sq_ctx.bmag);
            dneg_in = sq_ctx.bneg;
         end
         CASE_TWO: begin
            n1_s    = nb_s + s_s;
            n2_s    = nb_s - s_s;
            div_in  = DVW'({sq_ctx.amag, 1'b0});
            dneg_in = sq_ctx.aneg;
         end
         default: begin
            n1_s    = nb_s;
            div_in  = DVW'({sq_ctx.amag, 1'b0});
            dneg_in = sq_ctx.aneg;
         end
      endcase
   end

   assign n1_mag = n1_s[NSW-1] ? NMW'(NSW'(0) - n1_s) : NMW'(n1_s);
   assign n2_mag = n2_s[NSW-1] ? NMW'(NSW'(0) - n2_s) : NMW'(n2_s);
   assign tag_in = '{rcase: sq_ctx.rcase, neg1: n1_s[NSW-1] ^ dneg_in,
                     neg2: n2_s[NSW-1] ^ dneg_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_num1_ff <= n1_mag;
         s5_num2_ff <= n2_mag;
         s5_div_ff  <= div_in;
         s5_tag_ff  <= tag_in;
      end
   end

   // ---------------------------------------------------------------- divide
   assign dv_ctl = '{advance: advance, valid: s5_valid_ff};

   qrs_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (dv_ctl),
      .in_num1   (s5_num1_ff),
      .in_num2   (s5_num2_ff),
      .in_div    (s5_div_ff),
      .in_tag    (s5_tag_ff),
      .out_valid (dv_valid),
      .out_quo1  (dv_quo1),
      .out_quo2  (dv_quo2),
      .out_tag   (dv_tag)
   );

   // ---------------------------------------------------------------- output
   assign sat1 = root_sat(dv_quo1, dv_tag.neg1);
   assign sat2 = root_sat(dv_quo2, dv_tag.neg2);

   always_comb begin
      out_in           = '0;
      out_in.root_case = dv_tag.rcase;
      case (dv_tag.rcase)
         CASE_LINEAR, CASE_DOUBLE: begin
            out_in.first_root = sat1[31:0];
            out_in.overflow   = sat1[32];
         end
         CASE_TWO: begin
            out_in.first_root  = sat1[31:0];
            out_in.second_root = sat2[31:0];
            out_in.overflow    = sat1[32] | sat2[32];
         end
         default: begin
            out_in.first_root = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule
